@@ design/tis_pkg.sv @@
// Package for the timestamp interval search block.
// Holds table sizing, operation and status codes, and the transfer types.
// No dependencies.
`timescale 1ns / 1ps

package tis_pkg;

    localparam int ENTRIES = 256;
    localparam int AW      = $clog2(ENTRIES);
    localparam int CW      = $clog2(ENTRIES + 1);
    localparam int TW      = 23;

    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_cnt;
    typedef logic [TW-1:0] t_time;
    typedef logic [7:0]    t_index;
    typedef logic [8:0]    t_count;
    typedef logic [1:0]    t_func;
    typedef logic [1:0]    t_status;

    localparam t_func FUNC_CLEAR  = 2'd0;
    localparam t_func FUNC_APPEND = 2'd1;
    localparam t_func FUNC_SEARCH = 2'd2;
    localparam t_func FUNC_NOP    = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef struct packed {
        t_func func;
        t_time time_value;
    } t_in_item;

    typedef struct packed {
        t_status status;
        t_index  index;
        t_count  count;
    } t_out_item;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_time wdata;
        t_addr raddr;
    } t_ram_req;

endpackage

@@ design/tis_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module tis_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tis_core.sv @@
// Sequencer and shared compare unit for the timestamp interval search.
// Drives the table RAM port; depends on tis_pkg.
`timescale 1ns / 1ps

module tis_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tis_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    output logic              o_res_valid,
    output tis_pkg::t_out_item o_res,
    input  logic              i_res_take,
    output tis_pkg::t_ram_req o_ram,
    input  tis_pkg::t_time    i_rdata
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CHK_FIRST = 3'd1;
    localparam logic [2:0] S_CHK_LAST  = 3'd2;
    localparam logic [2:0] S_PROBE     = 3'd3;
    localparam logic [2:0] S_CHK_MID   = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    logic [2:0]       r_state, n_state;
    tis_pkg::t_time   r_q, n_q;
    tis_pkg::t_cnt    r_count, n_count;
    tis_pkg::t_addr   r_lo, n_lo;
    tis_pkg::t_addr   r_hi, n_hi;
    tis_pkg::t_addr   r_mid, n_mid;
    tis_pkg::t_status r_status, n_status;
    tis_pkg::t_addr   r_index, n_index;

    logic [tis_pkg::TW:0] diff;
    logic                 q_lt;
    logic                 q_gt;
    tis_pkg::t_addr       span;
    logic [tis_pkg::AW:0] sum;
    tis_pkg::t_addr       mid;
    tis_pkg::t_addr       last;
    logic                 in_take;

    assign diff    = {1'b0, r_q} - {1'b0, i_rdata};
    assign q_lt    = diff[tis_pkg::TW];
    assign q_gt    = !q_lt && (diff[tis_pkg::TW-1:0] != '0);
    assign span    = r_hi - r_lo;
    assign sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = sum[tis_pkg::AW:1];
    assign last    = tis_pkg::t_addr'(r_count - tis_pkg::t_cnt'(1));
    assign in_take = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_q      = r_q;
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_status = r_status;
        n_index  = r_index;
        o_ram.we    = 1'b0;
        o_ram.waddr = tis_pkg::t_addr'(r_count);
        o_ram.wdata = i_in_data.time_value;
        o_ram.raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state  = S_DONE;
                    n_status = tis_pkg::ST_OK;
                    n_index  = '0;
                    unique case (i_in_data.func)
                        tis_pkg::FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        tis_pkg::FUNC_APPEND: begin
                            if (r_count == tis_pkg::t_cnt'(tis_pkg::ENTRIES)) begin
                                n_status = tis_pkg::ST_FULL;
                            end else begin
                                o_ram.we = 1'b1;
                                n_count  = r_count + tis_pkg::t_cnt'(1);
                                n_index  = tis_pkg::t_addr'(r_count);
                            end
                        end
                        tis_pkg::FUNC_SEARCH: begin
                            n_q = i_in_data.time_value;
                            if (r_count == '0) begin
                                n_status = tis_pkg::ST_RANGE;
                            end else begin
                                n_state = S_CHK_FIRST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHK_FIRST: begin
                if (q_lt) begin
                    n_status = tis_pkg::ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    o_ram.raddr = last;
                    n_state     = S_CHK_LAST;
                end
            end
            S_CHK_LAST: begin
                if (q_gt) begin
                    n_status = tis_pkg::ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    n_lo    = '0;
                    n_hi    = last;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (span > tis_pkg::t_addr'(1)) begin
                    o_ram.raddr = mid;
                    n_mid       = mid;
                    n_state     = S_CHK_MID;
                end else begin
                    n_index = r_lo;
                    n_state = S_DONE;
                end
            end
            S_CHK_MID: begin
                if (!q_lt) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_PROBE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_q      <= n_q;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_status <= n_status;
        r_index  <= n_index;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.index  = tis_pkg::t_index'(r_index);
    assign o_res.count  = tis_pkg::t_count'(r_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tis_pkg::t_cnt'(tis_pkg::ENTRIES))
        else $error("entry count beyond table size");

    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_CHK_MID) |-> (r_lo <= r_hi))
        else $error("search bounds crossed");

    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK_MID) |-> (r_mid > r_lo && r_mid < r_hi))
        else $error("probe outside open interval");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (r_state == S_IDLE && i_in_valid))
        else $error("table write outside an append transfer");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |=> (r_count == $past(r_count) + tis_pkg::t_cnt'(1)))
        else $error("append did not advance count");
`endif

endmodule

@@ design/timestamp_interval_search_top.sv @@
// Top level of the timestamp interval search block.
// Depends on tis_pkg, tis_ram and tis_core.
// Use: send items on the input channel (i_in_valid / o_in_stall, payload
// i_in_data with func and time_value); one result per item returns on the
// output channel (o_out_valid / i_out_stall, payload o_out_data).
// func clear empties the table, append stores a timestamp at the next free
// slot (status full when all 256 slots hold data), search returns the start
// index of the interval holding the query time, or status out of range.
// Clear, append and no-op pass from the done state to the output register.
// A search checks the first entry, then the last, then halves the bounds
// with probes: each probe is one read of the table RAM plus one pass through
// the shared subtract-compare unit. One item is in flight at a time;
// o_in_stall is high from acceptance until its result moves to the output
// register, which may still hold the previous result while the next item
// is accepted. When the receiver stalls, the result holds in the output
// register and a finished item waits in the sequencer.
// Reset empties the table (count zero) and clears both valids; no clearing
// pass runs, as entries at or above the count are never read.
`timescale 1ns / 1ps

module timestamp_interval_search_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tis_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output tis_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    tis_pkg::t_ram_req  ram_req;
    tis_pkg::t_time     rdata;
    logic               res_valid;
    tis_pkg::t_out_item res;
    logic               res_take;

    logic               r_out_valid;
    tis_pkg::t_out_item r_out_data;

    tis_ram #(
        .WIDTH (tis_pkg::TW),
        .DEPTH (tis_pkg::ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    tis_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_ram       (ram_req),
        .i_rdata     (rdata)
    );

    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ bench/tb_timestamp_interval_search_top.sv @@
// Testbench for timestamp_interval_search_top: directed and random table operations.
// It predicts each result from its own copy of the table and checks every output transfer.
// Depends on tis_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_timestamp_interval_search_top;

    localparam int unsigned TMAX       = (1 << tis_pkg::TW) - 1;
    localparam int          RAND_ITEMS = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    tis_pkg::t_in_item  in_data = '0;
    logic               in_stall;
    logic               out_valid;
    tis_pkg::t_out_item out_data;
    logic               out_stall = 1'b0;

    timestamp_interval_search_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tis_pkg::t_time     ts_table [tis_pkg::ENTRIES];
    int                 ts_count = 0;
    tis_pkg::t_out_item pending_results [$];
    int                 mismatches = 0;
    int                 burst_left = 0;
    int                 gap_len = 0;
    int                 hold_req = 0;
    int                 items_sent = 0;

    function automatic tis_pkg::t_out_item table_step(input tis_pkg::t_in_item item);
        tis_pkg::t_out_item r;
        int                 lo;
        int                 hi;
        int                 mid;
        r = '0;
        case (item.func)
            tis_pkg::FUNC_CLEAR: begin
                ts_count = 0;
            end
            tis_pkg::FUNC_APPEND: begin
                if (ts_count >= tis_pkg::ENTRIES) begin
                    r.status = tis_pkg::ST_FULL;
                end else begin
                    ts_table[ts_count] = item.time_value;
                    r.index = tis_pkg::t_index'(ts_count);
                    ts_count++;
                end
            end
            tis_pkg::FUNC_SEARCH: begin
                if (ts_count == 0 || item.time_value < ts_table[0] ||
                    item.time_value > ts_table[ts_count-1]) begin
                    r.status = tis_pkg::ST_RANGE;
                end else begin
                    lo = 0;
                    hi = ts_count - 1;
                    while (hi - lo > 1) begin
                        mid = (lo + hi) / 2;
                        if (ts_table[mid] <= item.time_value) lo = mid;
                        else hi = mid;
                    end
                    r.index = tis_pkg::t_index'(lo);
                end
            end
            default: ;
        endcase
        r.count = tis_pkg::t_count'(ts_count);
        return r;
    endfunction

    task automatic send_item(input tis_pkg::t_func func, input int unsigned tv);
        tis_pkg::t_in_item item;
        item.func = func;
        item.time_value = tis_pkg::t_time'(tv);
        if (burst_left == 0) begin
            gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
        end else begin
            gap_len = 0;
        end
        burst_left--;
        @(negedge i_clk);
        if (gap_len > 0) begin
            in_valid <= 1'b0;
            repeat (gap_len) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        pending_results.push_back(table_step(item));
        if (func != tis_pkg::FUNC_NOP) items_sent++;
    endtask

    // receiver: long hold on request, otherwise stall at a rate that changes now and then
    always @(negedge i_clk) begin
        static int hold_left = 0;
        static int mode_left = 0;
        static int stall_pct = 0;
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 90;
                endcase
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        tis_pkg::t_out_item exp_r;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d index %0d count %0d",
                             out_data.status, out_data.index, out_data.count);
            end else begin
                exp_r = pending_results.pop_front();
                if (out_data.status !== exp_r.status || out_data.index !== exp_r.index ||
                    out_data.count !== exp_r.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected status %0d index %0d count %0d,",
                                  " got %0d %0d %0d"},
                                 exp_r.status, exp_r.index, exp_r.count,
                                 out_data.status, out_data.index, out_data.count);
                end
            end
        end
    end

    task automatic fill_ascending(input int n);
        int unsigned t;
        int unsigned max_step;
        t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, TMAX / 2);
        max_step = (TMAX - t) / n;
        for (int i = 0; i < n; i++) begin
            send_item(tis_pkg::FUNC_APPEND, t);
            t += $urandom_range(0, max_step);
        end
    endtask

    task automatic search_somewhere();
        int unsigned q;
        int unsigned first_t;
        int unsigned last_t;
        if (ts_count == 0) begin
            q = $urandom_range(0, TMAX);
        end else begin
            first_t = ts_table[0];
            last_t = ts_table[ts_count-1];
            case ($urandom_range(0, 4))
                0: q = ts_table[$urandom_range(0, ts_count - 1)];
                1: q = ts_table[$urandom_range(0, ts_count - 1)] + 1;
                2: q = (first_t > 0) ? $urandom_range(0, first_t - 1) : first_t;
                3: q = (last_t < TMAX) ? $urandom_range(last_t + 1, TMAX) : last_t;
                default: q = $urandom_range(0, TMAX);
            endcase
        end
        send_item(tis_pkg::FUNC_SEARCH, q & TMAX);
    endtask

    task automatic test_empty_and_nop();
        send_item(tis_pkg::FUNC_SEARCH, 0);
        send_item(tis_pkg::FUNC_SEARCH, TMAX);
        send_item(tis_pkg::FUNC_NOP, TMAX);
        send_item(tis_pkg::FUNC_CLEAR, TMAX);
        send_item(tis_pkg::FUNC_SEARCH, 5);
    endtask

    task automatic test_single_entry();
        send_item(tis_pkg::FUNC_APPEND, TMAX);
        send_item(tis_pkg::FUNC_SEARCH, TMAX);
        send_item(tis_pkg::FUNC_SEARCH, TMAX - 1);
        send_item(tis_pkg::FUNC_CLEAR, 0);
        send_item(tis_pkg::FUNC_APPEND, 0);
        send_item(tis_pkg::FUNC_SEARCH, 0);
        send_item(tis_pkg::FUNC_SEARCH, 1);
        send_item(tis_pkg::FUNC_NOP, 0);
    endtask

    task automatic test_bounds();
        send_item(tis_pkg::FUNC_CLEAR, 0);
        send_item(tis_pkg::FUNC_APPEND, 10);
        send_item(tis_pkg::FUNC_APPEND, 20);
        send_item(tis_pkg::FUNC_APPEND, 30);
        send_item(tis_pkg::FUNC_SEARCH, 9);
        send_item(tis_pkg::FUNC_SEARCH, 10);
        send_item(tis_pkg::FUNC_SEARCH, 20);
        send_item(tis_pkg::FUNC_SEARCH, 25);
        send_item(tis_pkg::FUNC_SEARCH, 30);
        send_item(tis_pkg::FUNC_SEARCH, 31);
        send_item(tis_pkg::FUNC_NOP, 12345);
    endtask

    task automatic test_unsorted();
        send_item(tis_pkg::FUNC_CLEAR, 0);
        send_item(tis_pkg::FUNC_APPEND, 50);
        send_item(tis_pkg::FUNC_APPEND, 10);
        send_item(tis_pkg::FUNC_APPEND, 40);
        send_item(tis_pkg::FUNC_APPEND, 5);
        send_item(tis_pkg::FUNC_APPEND, 60);
        send_item(tis_pkg::FUNC_SEARCH, 45);
        send_item(tis_pkg::FUNC_SEARCH, 30);
        send_item(tis_pkg::FUNC_SEARCH, 55);
    endtask

    task automatic test_full_table();
        send_item(tis_pkg::FUNC_CLEAR, 0);
        fill_ascending(tis_pkg::ENTRIES);
        send_item(tis_pkg::FUNC_APPEND, TMAX);
        send_item(tis_pkg::FUNC_SEARCH, ts_table[0]);
        send_item(tis_pkg::FUNC_SEARCH, ts_table[tis_pkg::ENTRIES-1]);
        send_item(tis_pkg::FUNC_SEARCH, ts_table[tis_pkg::ENTRIES/2]);
        repeat (8) search_somewhere();
        send_item(tis_pkg::FUNC_NOP, 0);
    endtask

    task automatic test_backpressure();
        hold_req = 400;
        burst_left = 40;
        repeat (6) search_somewhere();
        send_item(tis_pkg::FUNC_APPEND, TMAX);
        repeat (6) search_somewhere();
        send_item(tis_pkg::FUNC_CLEAR, 0);
        fill_ascending(8);
        repeat (6) search_somewhere();
    endtask

    task automatic test_random();
        int n;
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < RAND_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                send_item(tis_pkg::FUNC_CLEAR, $urandom_range(0, TMAX));
                if ($urandom_range(0, 59) == 0) n = $urandom_range(240, 260);
                else n = $urandom_range(1, 16);
                fill_ascending(n);
                repeat ($urandom_range(4, 12)) search_somewhere();
            end else begin
                repeat (10)
                    send_item(tis_pkg::t_func'($urandom_range(0, 3)),
                              $urandom_range(0, TMAX));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_nop();
        test_single_entry();
        test_bounds();
        test_unsorted();
        test_full_table();
        test_backpressure();
        test_random();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
